// ===== hdl/bhs_pkg.sv =====
// Shared types, constants and helper functions for the Braille haptic sequencer.
// Holds the phase codes, the six-dot letter table and the zero-length phase search.
// No dependencies.
package bhs_pkg;

  // Playback phase codes.
  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_STAGGER = 3'd1;
  localparam logic [2:0] PH_BUZZ    = 3'd2;
  localparam logic [2:0] PH_BEATGAP = 3'd3;
  localparam logic [2:0] PH_LETTGAP = 3'd4;
  localparam logic [2:0] PH_WORDGAP = 3'd5;

  // Where a row is entered: at its start, at its buzz, or after its buzz.
  localparam logic [1:0] AT_ROW  = 2'd0;
  localparam logic [1:0] AT_BUZZ = 2'd1;
  localparam logic [1:0] AT_GAP  = 2'd2;

  // Configuration register indexes.
  localparam int          CFG_IDX_W         = 3;
  localparam logic [2:0]  CFG_BUZZ          = 3'd0;
  localparam logic [2:0]  CFG_BEAT_GAP      = 3'd1;
  localparam logic [2:0]  CFG_LETTER_GAP    = 3'd2;
  localparam logic [2:0]  CFG_WORD_GAP      = 3'd3;
  localparam logic [2:0]  CFG_STAGGER       = 3'd4;

  // Register values after reset.
  localparam logic [15:0] BUZZ_RST          = 16'd400;
  localparam logic [15:0] BEAT_GAP_RST      = 16'd300;
  localparam logic [15:0] LETTER_GAP_RST    = 16'd800;
  localparam logic [15:0] WORD_GAP_RST      = 16'd1500;
  localparam logic [15:0] STAGGER_RST       = 16'd100;

  // Character codes.
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  typedef struct packed {
    logic [15:0] buzz_ms;
    logic [15:0] beat_gap_ms;
    logic [15:0] letter_gap_ms;
    logic [15:0] word_gap_ms;
    logic [15:0] stagger_ms;
  } cfg_t;

  // Flags telling which phases have a nonzero length.
  typedef struct packed {
    logic stagger;
    logic buzz;
    logic beat_gap;
    logic letter_gap;
    logic word_gap;
  } nz_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [1:0]  row;
    logic [5:0]  dots;
    logic [15:0] rem;
  } play_t;

  typedef struct packed {
    logic [2:0] phase;
    logic [1:0] row;
  } entry_t;

  // Payload of the character channel.
  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_code;
  } char_t;

  // Payload of the motor channel.
  typedef struct packed {
    logic motor_left;
    logic motor_right;
    logic busy_res;
    logic char_taken;
  } motor_t;

  // Six-dot Braille pattern of a lowercase letter; bit k is dot k+1.
  function automatic logic [5:0] letter_dots(input logic [4:0] idx);
    case (idx)
      5'd0:    return 6'h01;
      5'd1:    return 6'h03;
      5'd2:    return 6'h09;
      5'd3:    return 6'h19;
      5'd4:    return 6'h11;
      5'd5:    return 6'h0B;
      5'd6:    return 6'h1B;
      5'd7:    return 6'h13;
      5'd8:    return 6'h0A;
      5'd9:    return 6'h1A;
      5'd10:   return 6'h05;
      5'd11:   return 6'h07;
      5'd12:   return 6'h0D;
      5'd13:   return 6'h1D;
      5'd14:   return 6'h15;
      5'd15:   return 6'h0F;
      5'd16:   return 6'h1F;
      5'd17:   return 6'h17;
      5'd18:   return 6'h0E;
      5'd19:   return 6'h1E;
      5'd20:   return 6'h25;
      5'd21:   return 6'h27;
      5'd22:   return 6'h3A;
      5'd23:   return 6'h2D;
      5'd24:   return 6'h3D;
      5'd25:   return 6'h35;
      default: return 6'h00;
    endcase
  endfunction

  // Left column dot of a row; the unused fourth row reads dot four.
  function automatic logic row_left(input logic [5:0] dots, input logic [1:0] row);
    case (row)
      2'd0:    return dots[0];
      2'd1:    return dots[1];
      2'd2:    return dots[2];
      default: return dots[3];
    endcase
  endfunction

  // Right column dot of a row; the unused fourth row has none.
  function automatic logic row_right(input logic [5:0] dots, input logic [1:0] row);
    case (row)
      2'd0:    return dots[3];
      2'd1:    return dots[4];
      2'd2:    return dots[5];
      default: return 1'b0;
    endcase
  endfunction

  // Loaded length of a phase.
  function automatic logic [15:0] phase_len(input logic [2:0] phase, input cfg_t cfg);
    case (phase)
      PH_STAGGER: return cfg.stagger_ms;
      PH_BUZZ:    return cfg.buzz_ms;
      PH_BEATGAP: return cfg.beat_gap_ms;
      PH_LETTGAP: return cfg.letter_gap_ms;
      PH_WORDGAP: return cfg.word_gap_ms;
      default:    return 16'd0;
    endcase
  endfunction

  // Find the first phase of nonzero length from a point inside a letter.
  // Rows are walked from start_row to the third row; the third row, when it has no lead
  // or buzz to play, ends the search at the letter gap, or at idle when that gap is zero.
  function automatic entry_t find_entry(input logic [1:0] start_row,
                                        input logic [1:0] start_at,
                                        input logic [5:0] dots,
                                        input nz_t        nz);
    entry_t     res;
    logic       found;
    logic [1:0] st;
    logic [1:0] kk;
    res.phase = PH_IDLE;
    res.row   = start_row;
    found     = 1'b0;
    for (int k = 0; k < 3; k++) begin
      kk = 2'(k);
      st = (kk == start_row) ? start_at : AT_ROW;
      if (!found && kk >= start_row) begin
        if (st == AT_ROW && row_left(dots, kk) && row_right(dots, kk) && nz.stagger) begin
          res.phase = PH_STAGGER;
          res.row   = kk;
          found     = 1'b1;
        end else if (st != AT_GAP && nz.buzz) begin
          res.phase = PH_BUZZ;
          res.row   = kk;
          found     = 1'b1;
        end else if (kk == 2'd2) begin
          res.phase = nz.letter_gap ? PH_LETTGAP : PH_IDLE;
          res.row   = kk;
          found     = 1'b1;
        end else if (nz.beat_gap) begin
          res.phase = PH_BEATGAP;
          res.row   = kk;
          found     = 1'b1;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/bhs_stream_if.sv =====
// Valid/ready stream interface used by both channels of the sequencer.
// The payload type is set per instance; no dependencies.
interface bhs_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/bhs_step.sv =====
// Next-state and result logic for one millisecond tick of the sequencer.
// Depends on bhs_pkg for the phase codes, the letter table and the phase search.
module bhs_step (
  input  bhs_pkg::cfg_t   cfg,
  input  bhs_pkg::play_t  cur,
  input  logic            char_valid,
  input  logic [7:0]      char_code,
  output bhs_pkg::play_t  nxt,
  output bhs_pkg::motor_t res
);
  import bhs_pkg::*;

  nz_t        nz;
  logic       upper;
  logic [7:0] lc;
  logic       is_letter;
  logic [4:0] letter_idx;
  logic [5:0] new_dots;
  entry_t     start_ent;
  entry_t     end_ent;
  logic       taken;
  play_t      mid;
  logic [15:0] dec;

  // Phases that take time.
  always_comb begin
    nz.stagger    = cfg.stagger_ms != 16'd0;
    nz.buzz       = cfg.buzz_ms != 16'd0;
    nz.beat_gap   = cfg.beat_gap_ms != 16'd0;
    nz.letter_gap = cfg.letter_gap_ms != 16'd0;
    nz.word_gap   = cfg.word_gap_ms != 16'd0;
  end

  // Fold case and look the letter up.
  always_comb begin
    upper      = (char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_Z);
    lc         = upper ? char_code + CASE_OFFSET : char_code;
    is_letter  = (lc >= CHAR_LOWER_A) && (lc <= CHAR_LOWER_Z);
    letter_idx = 5'(lc - CHAR_LOWER_A);
    new_dots   = letter_dots(letter_idx);
    start_ent  = find_entry(2'd0, AT_ROW, new_dots, nz);
  end

  // Take a character when idle; the same tick then plays its first millisecond.
  always_comb begin
    taken = (cur.phase == PH_IDLE) && char_valid;
    mid   = cur;
    if (taken) begin
      if (is_letter) begin
        mid.dots  = new_dots;
        mid.phase = start_ent.phase;
        mid.row   = start_ent.row;
        mid.rem   = phase_len(start_ent.phase, cfg);
      end else if (lc == CHAR_SPACE) begin
        mid.phase = nz.word_gap ? PH_WORDGAP : PH_IDLE;
        mid.rem   = cfg.word_gap_ms;
      end
    end
  end

  // Play one millisecond and move on when the phase runs out.
  always_comb begin
    nxt             = mid;
    res.motor_left  = 1'b0;
    res.motor_right = 1'b0;
    res.char_taken  = taken;
    dec             = 16'd0;
    end_ent.phase   = PH_IDLE;
    end_ent.row     = mid.row;
    if (mid.phase != PH_IDLE) begin
      res.motor_left  = (mid.phase == PH_STAGGER) ||
                        ((mid.phase == PH_BUZZ) && row_left(mid.dots, mid.row));
      res.motor_right = (mid.phase == PH_BUZZ) && row_right(mid.dots, mid.row);
      dec             = (mid.rem != 16'd0) ? mid.rem - 16'd1 : 16'd0;
      nxt.rem         = dec;
      if (dec == 16'd0) begin
        case (mid.phase)
          PH_STAGGER: end_ent = find_entry(mid.row, AT_BUZZ, mid.dots, nz);
          PH_BUZZ:    end_ent = find_entry(mid.row, AT_GAP, mid.dots, nz);
          PH_BEATGAP: end_ent = find_entry(mid.row + 2'd1, AT_ROW, mid.dots, nz);
          default: begin
            end_ent.phase = PH_IDLE;
            end_ent.row   = mid.row;
          end
        endcase
        nxt.phase = end_ent.phase;
        nxt.row   = end_ent.row;
        nxt.rem   = phase_len(end_ent.phase, cfg);
      end
    end
    res.busy_res = nxt.phase != PH_IDLE;
  end

endmodule

// ===== hdl/braille_haptic_sequencer.sv =====
// Braille haptic sequencer top level: configuration registers, playback state
// and the registered motor result. Depends on bhs_pkg, bhs_stream_if and bhs_step.
// An accepted tick's result is registered in the output register. Throughput: one tick
// transaction per cycle unless motors stall; the output register frees in the cycle it drains.
// The playback state and the output register bound the rate; the step logic is single pass.
// Reset: registers return to their default lengths, playback goes idle, no result is held.
module braille_haptic_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  bhs_stream_if.sink            chars,
  bhs_stream_if.source          motors,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import bhs_pkg::*;

  cfg_t   cfg;
  play_t  state;
  play_t  state_next;
  motor_t step_res;
  motor_t result;
  logic   out_valid;
  logic   in_fire;
  char_t  char_item;

  assign char_item   = chars.data;
  assign chars.ready = !out_valid || motors.ready;
  assign in_fire     = chars.valid && chars.ready;

  assign motors.valid = out_valid;
  assign motors.data  = result;

  bhs_step u_step (
    .cfg        (cfg),
    .cur        (state),
    .char_valid (char_item.char_valid),
    .char_code  (char_item.char_code),
    .nxt        (state_next),
    .res        (step_res)
  );

  // Configuration writes; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.buzz_ms       <= BUZZ_RST;
      cfg.beat_gap_ms   <= BEAT_GAP_RST;
      cfg.letter_gap_ms <= LETTER_GAP_RST;
      cfg.word_gap_ms   <= WORD_GAP_RST;
      cfg.stagger_ms    <= STAGGER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUZZ:       cfg.buzz_ms       <= cfg_data;
        CFG_BEAT_GAP:   cfg.beat_gap_ms   <= cfg_data;
        CFG_LETTER_GAP: cfg.letter_gap_ms <= cfg_data;
        CFG_WORD_GAP:   cfg.word_gap_ms   <= cfg_data;
        CFG_STAGGER:    cfg.stagger_ms    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Playback state advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (motors.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= step_res;
    end
  end

  // A running phase always has time left on it.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    state.phase != PH_IDLE |-> state.rem != 16'd0)
    else $error("active phase with zero time remaining");

  // The stagger lead only runs on rows that fire both motors.
  a_stagger_both: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_STAGGER |->
      row_left(state.dots, state.row) && row_right(state.dots, state.row))
    else $error("stagger phase on a row without both dots");

  // A beat gap never follows the third row.
  a_beatgap_row: assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_BEATGAP |-> state.row < 2'd2)
    else $error("beat gap after the last row");

  // A character is never taken while playback is running.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && state.phase != PH_IDLE |=> !result.char_taken)
    else $error("character taken while busy");

endmodule

// ===== dv/bhs_tick_check_pkg.sv =====
// Scoreboard for the Braille haptic sequencer testbench: a tick-by-tick predictor
// of the playback sequence and a queue of expected motor transactions.
// Depends on bhs_pkg for the payload types, phase codes and register indexes.
package bhs_tick_check_pkg;
  import bhs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Six-dot cells of the letters a to z; bit k is dot k+1.
  localparam logic [5:0] CELL_OF_LETTER [26] = '{
    6'h01, 6'h03, 6'h09, 6'h19, 6'h11, 6'h0B, 6'h1B, 6'h13, 6'h0A, 6'h1A,
    6'h05, 6'h07, 6'h0D, 6'h1D, 6'h15, 6'h0F, 6'h1F, 6'h17, 6'h0E, 6'h1E,
    6'h25, 6'h27, 6'h3A, 6'h2D, 6'h3D, 6'h35
  };

  class tick_scoreboard;
    logic [15:0] buzz_len;
    logic [15:0] beat_gap_len;
    logic [15:0] letter_gap_len;
    logic [15:0] word_gap_len;
    logic [15:0] stagger_len;
    logic [2:0]  phase;
    logic [1:0]  row;
    logic [5:0]  dots;
    logic [15:0] ms_left;
    motor_t      expected_motor_q[$];
    int          errors;

    function new();
      buzz_len       = BUZZ_RST;
      beat_gap_len   = BEAT_GAP_RST;
      letter_gap_len = LETTER_GAP_RST;
      word_gap_len   = WORD_GAP_RST;
      stagger_len    = STAGGER_RST;
      phase          = PH_IDLE;
      row            = 2'd0;
      dots           = 6'd0;
      ms_left        = 16'd0;
      errors         = 0;
    endfunction

    // Mirror a register write; unknown indexes leave everything as it is.
    function void write_reg(input logic [2:0] idx, input logic [15:0] value);
      case (idx)
        CFG_BUZZ:       buzz_len = value;
        CFG_BEAT_GAP:   beat_gap_len = value;
        CFG_LETTER_GAP: letter_gap_len = value;
        CFG_WORD_GAP:   word_gap_len = value;
        CFG_STAGGER:    stagger_len = value;
        default: ;
      endcase
    endfunction

    function logic left_on();
      return dots[row];
    endfunction

    function logic right_on();
      return dots[row + 3];
    endfunction

    // A row whose both dots are raised opens with the left-only lead.
    function logic [2:0] row_entry();
      return (left_on() && right_on()) ? PH_STAGGER : PH_BUZZ;
    endfunction

    function logic [15:0] length_of(input logic [2:0] p);
      case (p)
        PH_STAGGER: return stagger_len;
        PH_BUZZ:    return buzz_len;
        PH_BEATGAP: return beat_gap_len;
        PH_LETTGAP: return letter_gap_len;
        PH_WORDGAP: return word_gap_len;
        default:    return 16'd0;
      endcase
    endfunction

    // Phase that follows p; leaving a beat gap moves on to the next row.
    function logic [2:0] successor(input logic [2:0] p);
      case (p)
        PH_STAGGER: return PH_BUZZ;
        PH_BUZZ:    return (row >= 2'd2) ? PH_LETTGAP : PH_BEATGAP;
        PH_BEATGAP: begin
          row = row + 2'd1;
          return row_entry();
        end
        default:    return PH_IDLE;
      endcase
    endfunction

    // Enter a phase, passing over every phase whose length is zero.
    function void start_phase(input logic [2:0] p);
      logic [2:0] nxt;
      nxt = p;
      while (nxt != PH_IDLE && length_of(nxt) == 16'd0)
        nxt = successor(nxt);
      phase   = nxt;
      ms_left = length_of(nxt);
    endfunction

    // One millisecond of playback; a character taken now plays at once.
    function motor_t play_tick(input char_t offer);
      motor_t     res;
      logic [7:0] code;
      res  = '0;
      code = offer.char_code;
      if (phase == PH_IDLE && offer.char_valid) begin
        res.char_taken = 1'b1;
        if (code >= "A" && code <= "Z")
          code = code + ("a" - "A");
        if (code >= "a" && code <= "z") begin
          dots = CELL_OF_LETTER[code - "a"];
          row  = 2'd0;
          start_phase(row_entry());
        end else if (code == " ") begin
          start_phase(PH_WORDGAP);
        end
      end
      if (phase != PH_IDLE) begin
        if (phase == PH_STAGGER) begin
          res.motor_left = 1'b1;
        end else if (phase == PH_BUZZ) begin
          res.motor_left  = left_on();
          res.motor_right = right_on();
        end
        if (ms_left != 16'd0)
          ms_left = ms_left - 16'd1;
        if (ms_left == 16'd0)
          start_phase(successor(phase));
      end
      res.busy_res = (phase != PH_IDLE);
      return res;
    endfunction

    // Note an accepted tick transaction and queue the motor result it causes.
    function void note_tick(input char_t offer);
      expected_motor_q.push_back(play_tick(offer));
    endfunction

    function void compare_bit(input string field, input logic want, input logic got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, want, got);
      end
    endfunction

    // Check a motor transaction against the oldest expectation.
    function void check_result(input motor_t got);
      motor_t want;
      if (expected_motor_q.size() == 0) begin
        errors++;
        $display("%0t: motor transaction with none expected, expected nothing, actual %b",
                 $time, got);
        return;
      end
      want = expected_motor_q.pop_front();
      compare_bit("motor_left", want.motor_left, got.motor_left);
      compare_bit("motor_right", want.motor_right, got.motor_right);
      compare_bit("busy_res", want.busy_res, got.busy_res);
      compare_bit("char_taken", want.char_taken, got.char_taken);
    endfunction

    function int pending();
      return expected_motor_q.size();
    endfunction

    function bit playing();
      return phase != PH_IDLE;
    endfunction
  endclass

endpackage

// ===== dv/tb_braille_haptic_sequencer.sv =====
// Testbench of the Braille haptic sequencer: drives tick transactions and register
// writes, predicts every motor transaction and checks it field by field.
// Depends on bhs_pkg, bhs_stream_if, bhs_tick_check_pkg and the sequencer RTL.
module tb_braille_haptic_sequencer;
  import bhs_pkg::*;
  import bhs_tick_check_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          SINK_HOLD_CYCLES = 300;
  localparam int          RANDOM_PHASES = 8;
  localparam logic [15:0] LEN_MAX = 16'hFFFF;

  // Boundary codes around the letter ranges, control and high codes.
  localparam logic [7:0] PROBE_CODES [13] = '{
    "a", "z", "A", "Z", "@", "[", 8'h60, "{", 8'h00, 8'hFF, 8'h80, " ", "y"
  };

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;
  bit                tx_idle;
  bit                rx_idle;
  bit                hold_sink;
  int unsigned       cycles;
  tick_scoreboard    sb;

  bhs_stream_if #(.payload_t(char_t))  char_if ();
  bhs_stream_if #(.payload_t(motor_t)) motor_if ();

  braille_haptic_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .chars     (char_if),
    .motors    (motor_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run-length guard.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** braille_haptic_sequencer: FAILED **");
      $finish;
    end
  end

  // Check every motor transaction as it is accepted.
  always @(posedge clk) begin
    if (!rst && motor_if.valid && motor_if.ready)
      sb.check_result(motor_if.data);
  end

  // Motor receiver: random stalls per transaction, and one long hold-off on request.
  initial begin
    int stall;
    motor_if.ready <= 1'b0;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        motor_if.ready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk);
      end
      stall = rx_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        motor_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      motor_if.ready <= 1'b1;
      do @(posedge clk); while (!motor_if.valid);
    end
  end

  function automatic char_t make_offer(input logic valid, input logic [7:0] code);
    char_t offer;
    offer.char_valid = valid;
    offer.char_code  = code;
    return offer;
  endfunction

  // Mostly letters of either case, some spaces, the rest any code at all.
  function automatic char_t random_offer();
    int         pick;
    logic [7:0] code;
    pick = $urandom_range(0, 99);
    if (pick < 35)
      code = 8'($urandom_range("a", "z"));
    else if (pick < 60)
      code = 8'($urandom_range("A", "Z"));
    else if (pick < 75)
      code = " ";
    else
      code = 8'($urandom_range(0, 255));
    return make_offer($urandom_range(0, 3) != 0, code);
  endfunction

  // Short lengths keep letters brief so that many of them get played.
  function automatic logic [15:0] short_len();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return 16'd0;
    else if (pick < 8)
      return 16'($urandom_range(1, 4));
    else
      return 16'($urandom_range(5, 24));
  endfunction

  // Offer one tick transaction and wait until it is accepted.
  task automatic send_tick(input char_t offer);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_if.valid <= 1'b1;
    char_if.data  <= offer;
    do @(posedge clk); while (!char_if.ready);
    sb.note_tick(offer);
  endtask

  // Keep ticking with random offers until the current sequence has played out.
  task automatic play_out();
    while (sb.playing())
      send_tick(random_offer());
  endtask

  // Stop offering and wait until every expected motor transaction has arrived.
  task automatic settle();
    char_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.write_reg(idx, value);
  endtask

  // Load all five lengths; optionally also hit the unused register indexes.
  task automatic apply_settings(input logic [15:0] buzz, input logic [15:0] beat_gap,
                                input logic [15:0] letter_gap, input logic [15:0] word_gap,
                                input logic [15:0] stagger, input bit poke_unused);
    write_reg(CFG_BUZZ, buzz);
    write_reg(CFG_BEAT_GAP, beat_gap);
    write_reg(CFG_LETTER_GAP, letter_gap);
    write_reg(CFG_WORD_GAP, word_gap);
    write_reg(CFG_STAGGER, stagger);
    if (poke_unused) begin
      for (int i = CFG_STAGGER + 1; i < (1 << CFG_IDX_W); i++)
        write_reg(CFG_IDX_W'(i), (i % 2 == 1) ? LEN_MAX : 16'd0);
    end
    cfg_we <= 1'b0;
  endtask

  // Stimulus.
  initial begin
    int n;
    sb             = new();
    cycles         = 0;
    tx_idle        = 1'b0;
    rx_idle        = 1'b0;
    hold_sink      = 1'b0;
    rst            <= 1'b1;
    char_if.valid  <= 1'b0;
    char_if.data   <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= '0;
    cfg_data       <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An uppercase letter with a staggered first row at the reset lengths.
    // Short lengths are written while its lead runs and apply from the next phase.
    send_tick(make_offer(1'b1, "Y"));
    settle();
    apply_settings(16'd3, 16'd1, 16'd2, 16'd2, 16'd1, 1'b1);
    play_out();

    // Boundary codes with short lengths; ignored codes are still taken.
    send_tick(make_offer(1'b0, 8'hFF));
    foreach (PROBE_CODES[i]) begin
      send_tick(make_offer(1'b1, PROBE_CODES[i]));
      play_out();
    end

    // All lengths zero: letters and spaces play nothing at all.
    settle();
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_tick(make_offer(1'b1, "q"));
    send_tick(make_offer(1'b1, " "));
    send_tick(make_offer(1'b1, "W"));

    // Zero buzz: buzzes take no time, the gaps and the lead still run.
    settle();
    apply_settings(16'd0, 16'd2, 16'd1, 16'd1, 16'd2, 1'b0);
    send_tick(make_offer(1'b1, "c"));
    play_out();

    // Random phases; settings change while a letter may still be playing.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      apply_settings(short_len(), short_len(), short_len(), short_len(), short_len(), 1'b0);
      tx_idle = (ph % 4 == 0) || (ph % 4 == 1);
      rx_idle = (ph % 4 == 0) || (ph % 4 == 2);
      if (ph == 2) begin
        // The receiver holds off while ticks keep coming back to back.
        tx_idle   = 1'b0;
        hold_sink = 1'b1;
      end
      n = $urandom_range(15, 25);
      for (int k = 0; k < n; k++) begin
        if (ph == 5 && k == n / 2)
          settle();
        send_tick(random_offer());
      end
    end

    settle();
    if (sb.errors == 0)
      $display("** braille_haptic_sequencer: PASSED **");
    else
      $display("** braille_haptic_sequencer: FAILED **");
    $finish;
  end

endmodule
